// File: rtl/core/wtfsf_pkg.sv
// ============================================================================
// wtfsf_pkg
// Shared types and constants of the transmit frame safety filter.
// ============================================================================
package wtfsf_pkg;

    localparam int unsigned MAC_W            = 48;
    localparam int unsigned LEN_W            = 12;
    localparam int unsigned FC_W             = 8;
    localparam int unsigned CMD_W            = 2;
    localparam int unsigned STATUS_W         = 4;
    localparam int unsigned COUNT_W          = 4;
    localparam int unsigned CFG_INDEX_W      = 1;
    localparam int unsigned CFG_DATA_W       = 48;
    localparam int unsigned MIN_HEADER_BYTES = 24;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    // frame-control byte fields
    localparam logic [FC_W-1:0] TYPE_MASK      = 8'h0C;
    localparam logic [FC_W-1:0] SUBTYPE_MASK   = 8'hF0;
    localparam logic [FC_W-1:0] TYPE_MGMT      = 8'h00;
    localparam logic [FC_W-1:0] TYPE_CTRL      = 8'h04;
    localparam logic [FC_W-1:0] TYPE_DATA      = 8'h08;
    localparam logic [FC_W-1:0] SUB_DISASSOC   = 8'hA0;
    localparam logic [FC_W-1:0] SUB_DEAUTH     = 8'hC0;
    localparam logic [FC_W-1:0] SUB_PROBE_RESP = 8'h50;

    typedef enum logic [CMD_W-1:0] {
        CMD_VALIDATE = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_REMOVE   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 4'd0,
        ST_NOT_ENABLED   = 4'd1,
        ST_TOO_SHORT     = 4'd2,
        ST_NO_BSSID      = 4'd3,
        ST_GROUP_DEAUTH  = 4'd4,
        ST_FOREIGN_BSSID = 4'd5,
        ST_NOT_OWN       = 4'd6,
        ST_INVALID       = 4'd7,
        ST_FULL          = 4'd8,
        ST_NOT_FOUND     = 4'd9
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_ENABLED = 1'd0,
        CFG_OWN_BSSID      = 1'd1
    } t_cfg_index;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [LEN_W-1:0] frame_length;
        logic [FC_W-1:0]  frame_control;
        logic [MAC_W-1:0] dest_address;
        logic [MAC_W-1:0] bssid_address;
        logic [MAC_W-1:0] station_mac;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  station_count;
    } t_out_item;

endpackage

// File: rtl/core/wifi_tx_frame_safety_filter_top.sv
// ============================================================================
// wifi_tx_frame_safety_filter_top
// Transmit-side 802.11 header gate with a table of associated stations.
// ============================================================================
// One transaction in gives exactly one result: a verdict for a validate
// command, or the outcome of an add or remove on the station table, always
// with the occupied-entry count after the action. The block takes one
// transaction per clock cycle while the result is not stalled; each one passes
// the input register, then the result register. The table keeps up because
// every entry is compared against the lookup key in parallel between the two
// registers, and the table write lands on the same edge as the result. A
// stall on the output holds the result register and, only if the input
// register is also full, stalls the input. Configuration (filter enable, own
// BSSID) must be written by the user through the config port while no
// transaction is in flight; the block itself does not enforce this. The
// config port is always ready. The station table is empty after reset, with
// no clearing pass.
// ============================================================================
module wifi_tx_frame_safety_filter_top #(
    parameter int unsigned TABLE_ENTRIES = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  wtfsf_pkg::t_in_item                     i_in_data,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output wtfsf_pkg::t_out_item                    o_out_data,
    // configuration write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [wtfsf_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [wtfsf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    // configuration registers
    logic                          r_filter_enabled;
    logic [wtfsf_pkg::MAC_W-1:0]   r_own_bssid;

    // station table: valid bits reset, mac payload does not need it
    logic [TABLE_ENTRIES-1:0]      r_entry_valid;
    logic [TABLE_ENTRIES-1:0]      n_entry_valid;
    logic [wtfsf_pkg::MAC_W-1:0]   r_entry_mac [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]      w_mac_we;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;

    // pipeline registers
    logic                          r_in_valid;
    wtfsf_pkg::t_in_item           r_in;
    logic                          r_out_valid;
    wtfsf_pkg::t_out_item          r_out;
    wtfsf_pkg::t_out_item          n_out;

    logic                          w_adv;
    logic                          w_in_accept;
    logic                          w_fire;

    // lookup
    logic [wtfsf_pkg::MAC_W-1:0]   w_key;
    logic [TABLE_ENTRIES-1:0]      w_match;
    logic [TABLE_ENTRIES-1:0]      w_match_1h;
    logic [TABLE_ENTRIES-1:0]      w_free;
    logic [TABLE_ENTRIES-1:0]      w_free_1h;
    logic                          w_known;

    // validate decode
    logic [wtfsf_pkg::FC_W-1:0]    w_type;
    logic [wtfsf_pkg::FC_W-1:0]    w_sub;
    logic                          w_a1_bcast;
    logic                          w_a1_group;
    logic                          w_a3_own;
    logic                          w_a3_bcast;
    wtfsf_pkg::t_status            w_verdict;

    // ------------------------------------------------------------------
    // handshakes: the result register drains or is empty -> stage moves
    // ------------------------------------------------------------------
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_fire      = r_in_valid && w_adv;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enabled <= 1'b0;
            r_own_bssid      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (wtfsf_pkg::t_cfg_index'(i_cfg_index))
                wtfsf_pkg::CFG_FILTER_ENABLED: begin
                    r_filter_enabled <= i_cfg_data[0];
                end
                wtfsf_pkg::CFG_OWN_BSSID: begin
                    r_own_bssid <= i_cfg_data[wtfsf_pkg::MAC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // parallel table lookup; one key serves all commands
    // ------------------------------------------------------------------
    assign w_key = (wtfsf_pkg::t_cmd'(r_in.command) == wtfsf_pkg::CMD_VALIDATE)
                 ? r_in.dest_address : r_in.station_mac;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_match[i] = r_entry_valid[i] && (r_entry_mac[i] == w_key);
        end
    end

    // lowest set bit isolation
    assign w_match_1h = w_match & (~w_match + TABLE_ENTRIES'(1));
    assign w_free     = ~r_entry_valid;
    assign w_free_1h  = w_free & (~w_free + TABLE_ENTRIES'(1));
    assign w_known    = |w_match;

    // ------------------------------------------------------------------
    // header checks, in priority order
    // ------------------------------------------------------------------
    assign w_type     = r_in.frame_control & wtfsf_pkg::TYPE_MASK;
    assign w_sub      = r_in.frame_control & wtfsf_pkg::SUBTYPE_MASK;
    assign w_a1_bcast = (r_in.dest_address == wtfsf_pkg::MAC_BCAST);
    assign w_a1_group = r_in.dest_address[0];
    assign w_a3_own   = (r_in.bssid_address == r_own_bssid);
    assign w_a3_bcast = (r_in.bssid_address == wtfsf_pkg::MAC_BCAST);

    always_comb begin
        w_verdict = wtfsf_pkg::ST_OK;
        if (!r_filter_enabled) begin
            w_verdict = wtfsf_pkg::ST_NOT_ENABLED;
        end else if (r_in.frame_length < wtfsf_pkg::LEN_W'(wtfsf_pkg::MIN_HEADER_BYTES)) begin
            w_verdict = wtfsf_pkg::ST_TOO_SHORT;
        end else if (r_own_bssid == '0) begin
            w_verdict = wtfsf_pkg::ST_NO_BSSID;
        end else if (w_type == wtfsf_pkg::TYPE_MGMT) begin
            if (w_sub == wtfsf_pkg::SUB_DEAUTH || w_sub == wtfsf_pkg::SUB_DISASSOC) begin
                // deauth / disassoc must target one of our own stations
                if (w_a1_bcast || w_a1_group) begin
                    w_verdict = wtfsf_pkg::ST_GROUP_DEAUTH;
                end else if (!w_a3_own) begin
                    w_verdict = wtfsf_pkg::ST_FOREIGN_BSSID;
                end else if (!w_known) begin
                    w_verdict = wtfsf_pkg::ST_NOT_OWN;
                end
            end else if (!w_a3_own && !w_a3_bcast) begin
                w_verdict = wtfsf_pkg::ST_FOREIGN_BSSID;
            end else if (!w_a1_bcast && !w_a1_group && !w_known
                         && w_sub != wtfsf_pkg::SUB_PROBE_RESP) begin
                // probe responses may go to stations not yet associated
                w_verdict = wtfsf_pkg::ST_NOT_OWN;
            end
        end else if (w_type == wtfsf_pkg::TYPE_DATA) begin
            if (!w_a1_bcast && !w_a1_group && !w_known) begin
                w_verdict = wtfsf_pkg::ST_NOT_OWN;
            end
        end else if (w_type == wtfsf_pkg::TYPE_CTRL) begin
            // control frames: an address other than broadcast must be a known station
            if (!w_a1_bcast && !w_known) begin
                w_verdict = wtfsf_pkg::ST_NOT_OWN;
            end
        end
        // reserved type passes
    end

    // ------------------------------------------------------------------
    // command execution: status, table update, count
    // ------------------------------------------------------------------
    always_comb begin
        n_entry_valid = r_entry_valid;
        w_mac_we      = '0;
        n_count       = r_count;
        n_out.status  = wtfsf_pkg::ST_OK;
        case (wtfsf_pkg::t_cmd'(r_in.command))
            wtfsf_pkg::CMD_VALIDATE: begin
                n_out.status = w_verdict;
            end
            wtfsf_pkg::CMD_ADD: begin
                if (r_in.station_mac == wtfsf_pkg::MAC_BCAST) begin
                    n_out.status = wtfsf_pkg::ST_INVALID;
                end else if (w_known) begin
                    // duplicate: nothing changes
                    n_out.status = wtfsf_pkg::ST_OK;
                end else if (|w_free) begin
                    n_entry_valid = r_entry_valid | w_free_1h;
                    w_mac_we      = w_free_1h;
                    n_count       = r_count + CNT_W'(1);
                end else begin
                    n_out.status = wtfsf_pkg::ST_FULL;
                end
            end
            wtfsf_pkg::CMD_REMOVE: begin
                if (w_known) begin
                    n_entry_valid = r_entry_valid & ~w_match_1h;
                    n_count       = r_count - CNT_W'(1);
                end else begin
                    n_out.status = wtfsf_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                // unused command code: ok, no change
                n_out.status = wtfsf_pkg::ST_OK;
            end
        endcase
        n_out.station_count = wtfsf_pkg::COUNT_W'(n_count);
    end

    // ------------------------------------------------------------------
    // table state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_count       <= '0;
        end else if (w_fire) begin
            r_entry_valid <= n_entry_valid;
            r_count       <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (w_fire && w_mac_we[i]) begin
                r_entry_mac[i] <= r_in.station_mac;
            end
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_accept || (r_in_valid && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/core/wtfsf_checker.sv
// ============================================================================
// wtfsf_props
// Port-level checks of the transmit frame safety filter.
// ============================================================================
module wtfsf_props #(
    parameter int unsigned TABLE_ENTRIES = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    o_in_stall,
    input  logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    input  wtfsf_pkg::t_out_item                    o_out_data
);

    localparam logic [wtfsf_pkg::COUNT_W-1:0] FULL_COUNT =
        wtfsf_pkg::COUNT_W'(TABLE_ENTRIES);

    // no result is left over after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // input only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // a full verdict reports a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == wtfsf_pkg::ST_FULL)
        |-> (o_out_data.station_count == FULL_COUNT))
        else $error("table full reported with wrong count");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind wifi_tx_frame_safety_filter_top wtfsf_props #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
) u_wtfsf_props (.*);
